### rtl/rgbhsl_pkg.sv
package rgbhsl_pkg;

  // Configuration register indexes
  localparam logic [2:0] RegHueLowA   = 3'd0;
  localparam logic [2:0] RegHueHighA  = 3'd1;
  localparam logic [2:0] RegHueLowB   = 3'd2;
  localparam logic [2:0] RegHueHighB  = 3'd3;
  localparam logic [2:0] RegSatLow    = 3'd4;
  localparam logic [2:0] RegSatHigh   = 3'd5;
  localparam logic [2:0] RegLightLow  = 3'd6;
  localparam logic [2:0] RegLightHigh = 3'd7;

  // Reset values of the window bounds
  localparam logic [7:0] RstHueLowA   = 8'd0;
  localparam logic [7:0] RstHueHighA  = 8'd20;
  localparam logic [7:0] RstHueLowB   = 8'd210;
  localparam logic [7:0] RstHueHighB  = 8'd255;
  localparam logic [7:0] RstSatLow    = 8'd100;
  localparam logic [7:0] RstSatHigh   = 8'd255;
  localparam logic [7:0] RstLightLow  = 8'd60;
  localparam logic [7:0] RstLightHigh = 8'd200;

  // Scale constants
  localparam logic [7:0] HueRed   = 8'd0;
  localparam logic [7:0] HueGreen = 8'd80;
  localparam logic [7:0] HueBlue  = 8'd160;
  localparam logic [7:0] HueWrap  = 8'd240;
  localparam logic [8:0] SumWrap  = 9'd511;
  localparam logic [7:0] BinMiss  = 8'd255;
  localparam logic [7:0] BinHit   = 8'd0;

  // Lightness = floor(sum*8/17), done as (sum*8 * 61681) >> 20
  localparam logic [15:0] LightRecip = 16'd61681;

  // Sum range that selects the 511-sum divisor (lightness 0 or above 120)
  localparam logic [8:0] SumLowMax  = 9'd2;
  localparam logic [8:0] SumHighMin = 9'd258;

  // Quotient bits, one per divider stage
  localparam int DivBitsDef = 8;

  // Which channel holds the maximum
  typedef enum logic [1:0] {
    MaxR = 2'd0,
    MaxG = 2'd1,
    MaxB = 2'd2
  } max_sel_e;

endpackage

### rtl/rgb565_hsl_color_threshold.sv
// RGB565 pixel to HSL (0..240) with a colour-window threshold.
// A pixel is registered in stage 1, stage 2, each divider stage, the HSL stage and the output register.
// Throughput: one pixel per cycle; a stalled output holds the whole pipeline.
// The quotient bits come from a restoring divider, one bit per register stage.
// Reset: pipeline emptied, window bounds return to their defaults.
module rgb565_hsl_color_threshold
  import rgbhsl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] pixel_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  hue_o,
  output logic [7:0]  saturation_o,
  output logic [7:0]  lightness_o,
  output logic [7:0]  binary_value_o
);

  localparam int RemW    = 17;
  localparam int DivBits = DivBitsDef;

  // Window bound registers
  logic [7:0] hue_low_a_q, hue_high_a_q, hue_low_b_q, hue_high_b_q;
  logic [7:0] sat_low_q, sat_high_q, light_low_q, light_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_low_a_q  <= RstHueLowA;
      hue_high_a_q <= RstHueHighA;
      hue_low_b_q  <= RstHueLowB;
      hue_high_b_q <= RstHueHighB;
      sat_low_q    <= RstSatLow;
      sat_high_q   <= RstSatHigh;
      light_low_q  <= RstLightLow;
      light_high_q <= RstLightHigh;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegHueLowA:   hue_low_a_q  <= cfg_data_i;
        RegHueHighA:  hue_high_a_q <= cfg_data_i;
        RegHueLowB:   hue_low_b_q  <= cfg_data_i;
        RegHueHighB:  hue_high_b_q <= cfg_data_i;
        RegSatLow:    sat_low_q    <= cfg_data_i;
        RegSatHigh:   sat_high_q   <= cfg_data_i;
        RegLightLow:  light_low_q  <= cfg_data_i;
        RegLightHigh: light_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Whole pipeline moves when the output slot is free or being taken
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Stage 1: channel expand, max/min, hue difference
  logic [7:0] r, g, b, mx, mn, ha, hb;
  max_sel_e   sel_d;
  logic       s1_vld_q;
  logic [7:0] s1_d_q, s1_adiff_q;
  logic [8:0] s1_sum_q;
  logic       s1_neg_q;
  max_sel_e   s1_sel_q;

  always_comb begin
    r = {pixel_i[15:11], 3'b000};
    g = {pixel_i[10:5], 2'b00};
    b = {pixel_i[4:0], 3'b000};
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    if (r >= g && r >= b) begin
      sel_d = MaxR; ha = g; hb = b;
    end else if (g >= b) begin
      sel_d = MaxG; ha = b; hb = r;
    end else begin
      sel_d = MaxB; ha = r; hb = g;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (adv) s1_vld_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_d_q     <= mx - mn;
      s1_sum_q   <= {1'b0, mx} + {1'b0, mn};
      s1_sel_q   <= sel_d;
      s1_neg_q   <= ha < hb;
      s1_adiff_q <= (ha < hb) ? (hb - ha) : (ha - hb);
    end
  end

  // Divider pipeline, element 0 is stage 2 (numerators, divisors, lightness)
  logic             dv_vld_q  [DivBits+1];
  logic [RemW-1:0]  dv_hrem_q [DivBits+1];
  logic [RemW-1:0]  dv_srem_q [DivBits+1];
  logic [7:0]       dv_hden_q [DivBits+1];
  logic [8:0]       dv_sden_q [DivBits+1];
  logic [7:0]       dv_hq_q   [DivBits+1];
  logic [7:0]       dv_sq_q   [DivBits+1];
  max_sel_e         dv_sel_q  [DivBits+1];
  logic             dv_neg_q  [DivBits+1];
  logic             dv_gray_q [DivBits+1];
  logic [7:0]       dv_l_q    [DivBits+1];

  // Stage 2 combinational
  logic [27:0] lprod;
  logic [8:0]  sden_d;
  assign lprod  = 28'({s1_sum_q, 3'b000}) * 28'(LightRecip);
  assign sden_d = (s1_sum_q <= SumLowMax || s1_sum_q >= SumHighMin) ?
                  (SumWrap - s1_sum_q) : s1_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_vld_q[0] <= 1'b0;
    else if (adv) dv_vld_q[0] <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_hrem_q[0] <= RemW'({s1_adiff_q, 5'b0}) + RemW'({s1_adiff_q, 3'b0});
      dv_srem_q[0] <= RemW'({s1_d_q, 8'b0}) - RemW'({s1_d_q, 4'b0});
      dv_hden_q[0] <= s1_d_q;
      dv_sden_q[0] <= sden_d;
      dv_hq_q[0]   <= '0;
      dv_sq_q[0]   <= '0;
      dv_sel_q[0]  <= s1_sel_q;
      dv_neg_q[0]  <= s1_neg_q;
      dv_gray_q[0] <= s1_d_q == '0;
      dv_l_q[0]    <= lprod[27:20];
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < DivBits; k++) begin : g_div
    localparam int Sh = DivBits - 1 - k;
    logic [RemW-1:0] htrial, strial;
    logic            hbit, sbit;
    assign htrial = RemW'(dv_hden_q[k]) << Sh;
    assign strial = RemW'(dv_sden_q[k]) << Sh;
    assign hbit   = dv_hrem_q[k] >= htrial;
    assign sbit   = dv_srem_q[k] >= strial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_vld_q[k+1] <= 1'b0;
      else if (adv) dv_vld_q[k+1] <= dv_vld_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_hrem_q[k+1] <= hbit ? (dv_hrem_q[k] - htrial) : dv_hrem_q[k];
        dv_srem_q[k+1] <= sbit ? (dv_srem_q[k] - strial) : dv_srem_q[k];
        dv_hq_q[k+1]   <= {dv_hq_q[k][6:0], hbit};
        dv_sq_q[k+1]   <= {dv_sq_q[k][6:0], sbit};
        dv_hden_q[k+1] <= dv_hden_q[k];
        dv_sden_q[k+1] <= dv_sden_q[k];
        dv_sel_q[k+1]  <= dv_sel_q[k];
        dv_neg_q[k+1]  <= dv_neg_q[k];
        dv_gray_q[k+1] <= dv_gray_q[k];
        dv_l_q[k+1]    <= dv_l_q[k];
      end
    end
  end

  // Hue assembly from sector offset and signed quotient
  logic [7:0] hq, base, hue_d;
  logic       hneg;
  assign hq   = dv_hq_q[DivBits];
  assign hneg = dv_neg_q[DivBits];

  always_comb begin
    case (dv_sel_q[DivBits])
      MaxR:    base = hneg ? HueWrap : HueRed;
      MaxG:    base = HueGreen;
      MaxB:    base = HueBlue;
      default: base = HueRed;
    endcase
    hue_d = hneg ? (base - hq) : (base + hq);
    if (dv_gray_q[DivBits]) hue_d = '0;
  end

  logic       hs_vld_q;
  logic [7:0] hs_h_q, hs_s_q, hs_l_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hs_vld_q <= 1'b0;
    else if (adv) hs_vld_q <= dv_vld_q[DivBits];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hs_h_q <= hue_d;
      hs_s_q <= dv_gray_q[DivBits] ? 8'd0 : dv_sq_q[DivBits];
      hs_l_q <= dv_l_q[DivBits];
    end
  end

  // Window test and output register
  logic hit;
  assign hit = ((hs_h_q > hue_low_a_q && hs_h_q < hue_high_a_q) ||
                (hs_h_q > hue_low_b_q && hs_h_q < hue_high_b_q)) &&
               (hs_s_q > sat_low_q && hs_s_q < sat_high_q) &&
               (hs_l_q > light_low_q && hs_l_q < light_high_q);

  logic       out_vld_q;
  logic [7:0] out_h_q, out_s_q, out_l_q, out_bin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= hs_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_h_q   <= hs_h_q;
      out_s_q   <= hs_s_q;
      out_l_q   <= hs_l_q;
      out_bin_q <= hit ? BinHit : BinMiss;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign hue_o          = out_h_q;
  assign saturation_o   = out_s_q;
  assign lightness_o    = out_l_q;
  assign binary_value_o = out_bin_q;

`ifndef SYNTH
  // Result codes and scale limits
  a_bin_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (binary_value_o == BinHit || binary_value_o == BinMiss))
    else $error("binary value not 0 or 255");

  a_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hue_o <= HueWrap && saturation_o <= HueWrap &&
                     lightness_o <= HueWrap))
    else $error("HSL value above 240");

  // A stalled pipeline keeps its result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(hue_o) &&
                                       $stable(binary_value_o)))
    else $error("result changed under stall");
`endif

endmodule
